// File: design/peus_pkg.sv
package peus_pkg;

    localparam int MAX_PARTICLES_DEF = 64;
    localparam logic [31:0] MAX_AGE_RESET = 32'h0064_0000;   // 100.0 in Q16.16

    localparam logic [1:0] FUNC_SPAWN = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] spawn_x;
        logic signed [31:0] spawn_y;
        logic signed [31:0] spawn_z;
        logic signed [31:0] spawn_vx;
        logic signed [31:0] spawn_vy;
        logic signed [31:0] spawn_vz;
        logic [31:0]        time_step;
    } t_in_req;

    typedef struct packed {
        logic               status;
        logic [6:0]         live_count;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               position_valid;
        logic               last;
    } t_out_res;

    // one stored particle, kept as a single memory word
    typedef struct packed {
        logic [31:0] age;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
    } t_part;

endpackage

// File: design/particle_euler_update_store.sv
// Particle store with Euler update. Spawn and clear each give one result. A tick
// walks each held particle through S_MX, S_MY, S_MZ and S_WR (one shared multiplier
// does the x, y and z moves in turn), reads the first survivor in S_E_RD, and
// then gives one surviving position per cycle while the output is not stalled;
// a tick on an empty store gives one result with no walk. The block takes no request while a tick is in
// progress. The particles live in one memory, written in compacted order.
module particle_euler_update_store
    import peus_pkg::*;
#(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_res    o_out_res,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MX, S_MY, S_MZ, S_WR, S_E_RD, S_E_LD, S_DONE
    } t_state;

    t_state         r_state;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_i;
    logic [CW-1:0]  r_n;
    logic [31:0]    r_max_age;
    logic [31:0]    r_step;
    logic [31:0]    r_age;
    logic [31:0]    r_x;
    logic [31:0]    r_y;
    logic           r_out_valid;
    t_out_res       r_out;

    logic           w_out_free;
    logic           w_accept;
    logic [CW-1:0]  w_i_inc;
    logic [CW-1:0]  w_n_inc;
    logic           w_i_last;
    logic           w_alive;
    logic [31:0]    w_z;
    logic [32:0]    w_age_sum;
    logic [CW-1:0]  w_new_count;
    logic           w_emit_load;
    logic           w_room;
    logic [CW-1:0]  w_idle_count;
    logic           w_out_set;

    logic           w_we;
    logic [AW-1:0]  w_waddr;
    t_part          w_wdata;
    logic           w_re;
    logic [AW-1:0]  w_raddr;
    t_part          w_rdata;
    logic [31:0]    w_mul_vel;
    logic [31:0]    w_move;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !w_out_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_i_inc     = r_i + CW'(1);
    assign w_n_inc     = r_n + CW'(1);
    assign w_i_last    = (w_i_inc == r_count);
    assign w_alive     = (r_age < r_max_age);
    assign w_z         = w_rdata.pz + w_move;
    assign w_age_sum   = {1'b0, w_rdata.age} + {1'b0, r_step};
    assign w_new_count = w_alive ? w_n_inc : r_n;
    assign w_emit_load = (r_state == S_E_LD) && w_out_free;
    assign w_room      = (r_count < CW'(MAX_PARTICLES));

    // count after a request taken in idle
    assign w_idle_count = (i_in_req.func == FUNC_CLEAR) ? '0 :
                          ((i_in_req.func == FUNC_SPAWN) && w_room) ? r_count + CW'(1) :
                          r_count;

    // a tick on a non-empty store answers later from the walk
    assign w_out_set = ((r_state == S_IDLE) && w_accept
                        && !((i_in_req.func == FUNC_TICK) && (r_count != '0)))
                       || (((r_state == S_E_LD) || (r_state == S_DONE)) && w_out_free);

    // memory and multiplier control
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_n[AW-1:0];
        w_wdata   = '{age: r_age, vx: w_rdata.vx, vy: w_rdata.vy, vz: w_rdata.vz,
                      px: r_x, py: r_y, pz: w_z};
        w_re      = 1'b0;
        w_raddr   = w_i_inc[AW-1:0];
        w_mul_vel = w_rdata.vx;
        case (r_state)
            S_IDLE: begin
                w_waddr = r_count[AW-1:0];
                w_wdata = '{age: '0, vx: i_in_req.spawn_vx, vy: i_in_req.spawn_vy,
                            vz: i_in_req.spawn_vz, px: i_in_req.spawn_x,
                            py: i_in_req.spawn_y, pz: i_in_req.spawn_z};
                w_we    = w_accept && (i_in_req.func == FUNC_SPAWN) && w_room;
                w_re    = w_accept && (i_in_req.func == FUNC_TICK);
                w_raddr = '0;
            end
            S_MY:   w_mul_vel = w_rdata.vy;
            S_MZ:   w_mul_vel = w_rdata.vz;
            S_WR: begin
                w_we = w_alive;
                w_re = !w_i_last;
            end
            S_E_RD: begin
                w_re    = 1'b1;
                w_raddr = r_i[AW-1:0];
            end
            S_E_LD: w_re = w_emit_load && !w_i_last;
            default: ;
        endcase
    end

    peus_ram #(
        .WIDTH ($bits(t_part)),
        .DEPTH (MAX_PARTICLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    peus_mul u_mul (
        .i_clk  (i_clk),
        .i_vel  (w_mul_vel),
        .i_step (r_step),
        .o_move (w_move)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_max_age   <= MAX_AGE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_max_age <= i_cfg_data;
            end
            if (w_out_set) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_step               <= i_in_req.time_step;
                        r_i                  <= '0;
                        r_n                  <= '0;
                        r_count              <= w_idle_count;
                        r_out.status         <= ((i_in_req.func == FUNC_SPAWN) && !w_room)
                                                ? STATUS_DROPPED : STATUS_DONE;
                        r_out.live_count     <= 7'(w_idle_count);
                        r_out.out_x          <= '0;
                        r_out.out_y          <= '0;
                        r_out.out_z          <= '0;
                        r_out.position_valid <= 1'b0;
                        r_out.last           <= 1'b1;
                        if ((i_in_req.func == FUNC_TICK) && (r_count != '0)) begin
                            r_state <= S_MX;
                        end
                    end
                end
                S_MX: begin
                    r_age   <= w_age_sum[32] ? 32'hFFFF_FFFF : w_age_sum[31:0];
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_x     <= w_rdata.px + w_move;
                    r_state <= S_MZ;
                end
                S_MZ: begin
                    r_y     <= w_rdata.py + w_move;
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_n <= w_new_count;
                    if (w_i_last) begin
                        r_count <= w_new_count;
                        r_i     <= '0;
                        r_state <= (w_new_count == '0) ? S_DONE : S_E_RD;
                    end else begin
                        r_i     <= w_i_inc;
                        r_state <= S_MX;
                    end
                end
                S_E_RD: r_state <= S_E_LD;
                S_E_LD: begin
                    if (w_out_free) begin
                        r_out.status         <= STATUS_DONE;
                        r_out.live_count     <= 7'(r_count);
                        r_out.out_x          <= w_rdata.px;
                        r_out.out_y          <= w_rdata.py;
                        r_out.out_z          <= w_rdata.pz;
                        r_out.position_valid <= 1'b1;
                        r_out.last           <= w_i_last;
                        r_i                  <= w_i_inc;
                        if (w_i_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DONE: begin
                    // every particle expired
                    if (w_out_free) begin
                        r_out.status         <= STATUS_DONE;
                        r_out.live_count     <= '0;
                        r_out.out_x          <= '0;
                        r_out.out_y          <= '0;
                        r_out.out_z          <= '0;
                        r_out.position_valid <= 1'b0;
                        r_out.last           <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

// File: design/peus_ram.sv
module peus_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/peus_mul.sv
module peus_mul
    import peus_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_vel,
    input  logic [31:0] i_step,
    output logic [31:0] o_move
);

    // signed velocity times unsigned step; bits 47:16 are the floored Q16.16 move
    logic signed [65:0] w_prod;
    logic [31:0]        r_move;

    assign w_prod = $signed({i_vel[31], i_vel}) * $signed({1'b0, i_step});

    always_ff @(posedge i_clk) begin
        r_move <= w_prod[47:16];
    end

    assign o_move = r_move;

endmodule
